[hdl/tpba_pkg.sv]
// ----------------------------------------------------------------------------
// tpba_pkg
// Shared constants, codes and types of the two-zone page bitmap allocator.
// ----------------------------------------------------------------------------
package tpba_pkg;

	localparam int MAX_PAGES      = 4096;
	localparam int LOW_ZONE_PAGES = 256;
	localparam int PAGE_BYTES     = 4096;

	localparam int BITS_PER_WORD = 32;
	localparam int BIT_W         = $clog2(BITS_PER_WORD);
	localparam int WORDS         = MAX_PAGES / BITS_PER_WORD;
	localparam int LOW_WORDS     = LOW_ZONE_PAGES / BITS_PER_WORD;
	localparam int WORD_AW       = $clog2(WORDS);
	localparam int WORD_CW       = WORD_AW + 1;
	localparam int PAGE_SHIFT    = $clog2(PAGE_BYTES);
	localparam int ADDR_W        = 32;
	localparam int PAGE_NUM_W    = ADDR_W - PAGE_SHIFT;
	localparam int PIDX_W        = $clog2(MAX_PAGES);
	localparam int PCNT_W        = 13;
	localparam int UP_CNT_W      = 12;
	localparam int LOW_CNT_W     = 9;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_FREE    = 2'd1,
		OP_RESERVE = 2'd2,
		OP_NONE    = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_OOM   = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic take;
		logic low;
	} ctr_upd_t;

endpackage

[hdl/tpba_ram.sv]
// ----------------------------------------------------------------------------
// tpba_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module tpba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[hdl/tpba_bit_unit.sv]
// ----------------------------------------------------------------------------
// tpba_bit_unit
// Shared word unit: full test, highest free bit search and word update.
// ----------------------------------------------------------------------------
module tpba_bit_unit (
	input  tpba_pkg::opcode_t                     op,
	input  logic [tpba_pkg::BITS_PER_WORD-1:0]    word,
	input  logic [tpba_pkg::BITS_PER_WORD-1:0]    mask,
	output logic                                  full,
	output logic [tpba_pkg::BIT_W-1:0]            top_bit,
	output logic [tpba_pkg::BITS_PER_WORD-1:0]    new_word
);
	import tpba_pkg::*;

	logic [BITS_PER_WORD-1:0] take_mask;

	assign full = &word;

	// highest clear bit wins
	always_comb begin
		top_bit = '0;
		for (int i = 0; i < BITS_PER_WORD; i++) begin
			if (!word[i]) begin
				top_bit = BIT_W'(i);
			end
		end
	end

	assign take_mask = BITS_PER_WORD'(1) << top_bit;

	always_comb begin
		case (op)
			OP_ALLOC:   new_word = word | take_mask;
			OP_FREE:    new_word = word & ~mask;
			OP_RESERVE: new_word = word | mask;
			default:    new_word = word;
		endcase
	end

endmodule

[hdl/tpba_zone_ctr.sv]
// ----------------------------------------------------------------------------
// tpba_zone_ctr
// Page count register and the free/used counters of both zones.
// ----------------------------------------------------------------------------
module tpba_zone_ctr (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [tpba_pkg::PCNT_W-1:0]      cfg_wr_data,
	input  tpba_pkg::ctr_upd_t               upd,
	output logic [tpba_pkg::PCNT_W-1:0]      pages,
	output logic [tpba_pkg::UP_CNT_W-1:0]    upper_free,
	output logic [tpba_pkg::UP_CNT_W-1:0]    upper_used,
	output logic [tpba_pkg::LOW_CNT_W-1:0]   low_free,
	output logic [tpba_pkg::LOW_CNT_W-1:0]   low_used
);
	import tpba_pkg::*;

	logic [PCNT_W-1:0]    mem_pages_q;
	logic [PCNT_W-1:0]    cfg_pages;
	logic [PCNT_W-1:0]    upper_size;
	logic [PCNT_W-1:0]    cfg_upper_size;
	logic [UP_CNT_W-1:0]  upper_free_q;
	logic [UP_CNT_W-1:0]  upper_used_q;
	logic [LOW_CNT_W-1:0] low_free_q;
	logic [LOW_CNT_W-1:0] low_used_q;

	function automatic logic [PCNT_W-1:0] clamp_pages(input logic [PCNT_W-1:0] p);
		logic [PCNT_W-1:0] r;
		r = p;
		if (p < PCNT_W'(LOW_ZONE_PAGES)) r = PCNT_W'(LOW_ZONE_PAGES);
		if (p > PCNT_W'(MAX_PAGES)) r = PCNT_W'(MAX_PAGES);
		return r;
	endfunction

	assign pages          = clamp_pages(mem_pages_q);
	assign cfg_pages      = clamp_pages(cfg_wr_data);
	assign upper_size     = pages - PCNT_W'(LOW_ZONE_PAGES);
	assign cfg_upper_size = cfg_pages - PCNT_W'(LOW_ZONE_PAGES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_pages_q  <= PCNT_W'(MAX_PAGES);
			upper_free_q <= UP_CNT_W'(MAX_PAGES - LOW_ZONE_PAGES);
			upper_used_q <= '0;
			low_free_q   <= LOW_CNT_W'(LOW_ZONE_PAGES);
			low_used_q   <= '0;
		end else if (cfg_wr_en) begin
			mem_pages_q  <= cfg_wr_data;
			upper_free_q <= cfg_upper_size[UP_CNT_W-1:0];
			upper_used_q <= '0;
			low_free_q   <= LOW_CNT_W'(LOW_ZONE_PAGES);
			low_used_q   <= '0;
		end else if (upd.take) begin
			if (upd.low) begin
				if (low_used_q < LOW_CNT_W'(LOW_ZONE_PAGES)) begin
					low_used_q <= low_used_q + LOW_CNT_W'(1);
				end
				if (low_free_q != '0) low_free_q <= low_free_q - LOW_CNT_W'(1);
			end else begin
				if (PCNT_W'(upper_used_q) < upper_size) begin
					upper_used_q <= upper_used_q + UP_CNT_W'(1);
				end
				if (upper_free_q != '0) upper_free_q <= upper_free_q - UP_CNT_W'(1);
			end
		end
	end

	assign upper_free = upper_free_q;
	assign upper_used = upper_used_q;
	assign low_free   = low_free_q;
	assign low_used   = low_used_q;

	// free and used of a zone always add up to the zone size
	a_low_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(LOW_CNT_W + 1)'(low_free_q) + (LOW_CNT_W + 1)'(low_used_q)
			== (LOW_CNT_W + 1)'(LOW_ZONE_PAGES))
		else $error("low zone counters out of step");

	a_upper_sum: assert property (@(posedge clk) disable iff (!arst_n)
		PCNT_W'(upper_free_q) + PCNT_W'(upper_used_q) == upper_size)
		else $error("upper zone counters out of step");

endmodule

[hdl/two_zone_page_bitmap_allocator.sv]
// ----------------------------------------------------------------------------
// two_zone_page_bitmap_allocator
// Page frame bitmap with a low DMA zone and an upper zone; allocate, free and
// reserve walk the bitmap RAM one word per cycle through a shared word unit.
// ----------------------------------------------------------------------------
// words walked: free 1, reserve up to 128, allocate with no free page up to 120;
// an allocate stops at the word in which it finds its page, and some items walk
// no word at all; a held result delays the finish
// throughput: one item at a time, next beat taken the cycle after the result loads
// reset: clears per-word valid bits, so the whole bitmap reads as free at once
// with no clearing pass; counters reload from the 4096-page reset value
module two_zone_page_bitmap_allocator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [tpba_pkg::PCNT_W-1:0]       cfg_wr_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        opcode,
	input  logic                              low_zone,
	input  logic [31:0]                       byte_address,
	input  logic [31:0]                       byte_length,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        status,
	output logic [31:0]                       page_address,
	output logic [tpba_pkg::UP_CNT_W-1:0]     upper_free_pages,
	output logic [tpba_pkg::UP_CNT_W-1:0]     upper_used_pages,
	output logic [tpba_pkg::LOW_CNT_W-1:0]    low_free_pages,
	output logic [tpba_pkg::LOW_CNT_W-1:0]    low_used_pages
);
	import tpba_pkg::*;

	state_t state_q, state_d;

	// walk control
	opcode_t                  op_q;
	logic                     low_q;
	status_t                  status_q;
	logic [WORD_CW-1:0]       issue_q;
	logic [WORD_CW-1:0]       end_q;
	logic [WORD_AW-1:0]       first_w_q;
	logic [WORD_AW-1:0]       last_w_q;
	logic [BIT_W-1:0]         lo_q;
	logic [BIT_W-1:0]         hi_q;
	logic [PIDX_W-1:0]        page_q;

	// read in flight
	logic                     pend_s1;
	logic                     valid_s1;
	logic [WORD_AW-1:0]       word_s1;
	logic [BITS_PER_WORD-1:0] mask_s1;

	logic [WORDS-1:0]         valid_q;

	// output register
	logic                     out_valid_q;
	status_t                  out_status_q;
	logic [ADDR_W-1:0]        out_page_q;
	logic [UP_CNT_W-1:0]      out_upper_free_q;
	logic [UP_CNT_W-1:0]      out_upper_used_q;
	logic [LOW_CNT_W-1:0]     out_low_free_q;
	logic [LOW_CNT_W-1:0]     out_low_used_q;

	// counters
	logic [PCNT_W-1:0]        pages;
	logic [UP_CNT_W-1:0]      upper_free;
	logic [UP_CNT_W-1:0]      upper_used;
	logic [LOW_CNT_W-1:0]     low_free;
	logic [LOW_CNT_W-1:0]     low_used;
	ctr_upd_t                 ctr_upd;

	// handshake and control
	logic                     in_accept;
	logic                     out_take;
	logic                     slot_free;
	logic                     issue_ok;
	logic                     found;
	logic                     walk_done;
	logic                     rd_en;
	logic                     wr_en;
	logic [BITS_PER_WORD-1:0] rd_data;
	logic [BITS_PER_WORD-1:0] cur_word;
	logic                     full;
	logic [BIT_W-1:0]         top_bit;
	logic [BITS_PER_WORD-1:0] new_word;
	logic [BIT_W-1:0]         lo_sel;
	logic [BIT_W-1:0]         hi_sel;
	logic [BITS_PER_WORD-1:0] issue_mask;

	// input decode
	opcode_t                  in_op;
	logic [PAGE_NUM_W-1:0]    page_in;
	logic [PAGE_NUM_W-1:0]    len_pg;
	logic                     in_range;
	logic [PAGE_NUM_W:0]      end_sum;
	logic [PCNT_W-1:0]        end_cl;
	logic [PCNT_W-1:0]        last_full;
	logic [PIDX_W-1:0]        last_pg;
	logic [PCNT_W-1:0]        upper_size;
	logic [WORD_AW-1:0]       start_w;
	logic [WORD_AW-1:0]       last_w;

	// walk set-up taken on accept
	logic [WORD_CW-1:0]       setup_issue;
	logic [WORD_CW-1:0]       setup_end;
	status_t                  setup_status;
	logic [WORD_AW-1:0]       setup_last_w;
	logic [BIT_W-1:0]         setup_hi;

	assign in_op      = opcode_t'(opcode);
	assign page_in    = byte_address[ADDR_W-1:PAGE_SHIFT];
	assign len_pg     = byte_length[ADDR_W-1:PAGE_SHIFT];
	assign in_range   = page_in < PAGE_NUM_W'(pages);
	assign end_sum    = (PAGE_NUM_W + 1)'(page_in) + (PAGE_NUM_W + 1)'(len_pg);
	assign end_cl     = (end_sum > (PAGE_NUM_W + 1)'(pages)) ? pages : end_sum[PCNT_W-1:0];
	assign last_full  = end_cl - PCNT_W'(1);
	assign last_pg    = last_full[PIDX_W-1:0];
	assign upper_size = pages - PCNT_W'(LOW_ZONE_PAGES);
	assign start_w    = page_in[PIDX_W-1:BIT_W];
	assign last_w     = last_pg[PIDX_W-1:BIT_W];

	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_take  = out_valid_q && !out_stall;
	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		setup_issue  = '0;
		setup_end    = '0;
		setup_status = ST_DONE;
		setup_last_w = start_w;
		setup_hi     = page_in[BIT_W-1:0];
		case (in_op)
			OP_ALLOC: begin
				if (low_zone) begin
					setup_end = WORD_CW'(LOW_WORDS);
				end else begin
					setup_issue = WORD_CW'(LOW_WORDS);
					setup_end   = WORD_CW'(LOW_WORDS)
						+ WORD_CW'(upper_size[PCNT_W-1:BIT_W]);
				end
			end
			OP_FREE: begin
				if (in_range) begin
					setup_issue = WORD_CW'(start_w);
					setup_end   = WORD_CW'(start_w) + WORD_CW'(1);
				end else begin
					setup_status = ST_RANGE;
				end
			end
			OP_RESERVE: begin
				if (!in_range) begin
					setup_status = ST_RANGE;
				end else if (len_pg != '0) begin
					setup_issue  = WORD_CW'(start_w);
					setup_end    = WORD_CW'(last_w) + WORD_CW'(1);
					setup_last_w = last_w;
					setup_hi     = last_pg[BIT_W-1:0];
				end
			end
			default: begin
				setup_status = ST_DONE;
			end
		endcase
	end

	// ------------------------------------------------------------------ walk

	assign issue_ok = issue_q < end_q;
	assign cur_word = valid_s1 ? rd_data : '0;
	assign found    = (state_q == S_WALK) && pend_s1 && (op_q == OP_ALLOC) && !full;
	assign walk_done = (state_q == S_WALK) && !pend_s1 && !issue_ok;

	assign lo_sel     = (issue_q[WORD_AW-1:0] == first_w_q) ? lo_q : '0;
	assign hi_sel     = (issue_q[WORD_AW-1:0] == last_w_q) ? hi_q : BIT_W'(BITS_PER_WORD - 1);
	assign issue_mask = ({BITS_PER_WORD{1'b1}} << lo_sel)
		& ({BITS_PER_WORD{1'b1}} >> (BIT_W'(BITS_PER_WORD - 1) - hi_sel));

	tpba_bit_unit u_bit_unit (
		.op       (op_q),
		.word     (cur_word),
		.mask     (mask_s1),
		.full     (full),
		.top_bit  (top_bit),
		.new_word (new_word)
	);

	tpba_ram #(
		.WIDTH (BITS_PER_WORD),
		.DEPTH (WORDS)
	) u_bitmap (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (word_s1),
		.wr_data (new_word),
		.rd_en   (rd_en),
		.rd_addr (issue_q[WORD_AW-1:0]),
		.rd_data (rd_data)
	);

	tpba_zone_ctr u_zone_ctr (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.upd         (ctr_upd),
		.pages       (pages),
		.upper_free  (upper_free),
		.upper_used  (upper_used),
		.low_free    (low_free),
		.low_used    (low_used)
	);

	// ------------------------------------------------------------ sequencer

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_accept) state_d = S_WALK;
			end
			S_WALK: begin
				if (found || walk_done) state_d = S_FINISH;
			end
			S_FINISH: begin
				if (slot_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		rd_en        = 1'b0;
		wr_en        = 1'b0;
		ctr_upd.take = 1'b0;
		ctr_upd.low  = low_q;
		case (state_q)
			S_WALK: begin
				rd_en = issue_ok;
				if (op_q == OP_ALLOC) begin
					wr_en        = found;
					ctr_upd.take = found;
				end else begin
					wr_en = pend_s1;
				end
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pend_s1     <= 1'b0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_accept) begin
				pend_s1 <= 1'b0;
			end else if (state_q == S_WALK) begin
				pend_s1 <= issue_ok;
			end
			if (wr_en) begin
				valid_q[word_s1] <= 1'b1;
			end
			if (state_q == S_FINISH && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// walk set-up on accept, then one word issued per cycle
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q      <= in_op;
			low_q     <= low_zone;
			status_q  <= setup_status;
			issue_q   <= setup_issue;
			end_q     <= setup_end;
			first_w_q <= start_w;
			last_w_q  <= setup_last_w;
			lo_q      <= page_in[BIT_W-1:0];
			hi_q      <= setup_hi;
		end else if (state_q == S_WALK) begin
			if (issue_ok) begin
				issue_q <= issue_q + WORD_CW'(1);
			end
			word_s1  <= issue_q[WORD_AW-1:0];
			valid_s1 <= valid_q[issue_q[WORD_AW-1:0]];
			mask_s1  <= issue_mask;
			if (found) begin
				page_q <= {word_s1, top_bit};
			end
			if (walk_done && op_q == OP_ALLOC) begin
				status_q <= ST_OOM;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FINISH && slot_free) begin
			out_status_q     <= status_q;
			out_page_q       <= (op_q == OP_ALLOC && status_q == ST_DONE)
				? (ADDR_W'(page_q) << PAGE_SHIFT) : '0;
			out_upper_free_q <= upper_free;
			out_upper_used_q <= upper_used;
			out_low_free_q   <= low_free;
			out_low_used_q   <= low_used;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = out_status_q;
	assign page_address     = out_page_q;
	assign upper_free_pages = out_upper_free_q;
	assign upper_used_pages = out_upper_used_q;
	assign low_free_pages   = out_low_free_q;
	assign low_used_pages   = out_low_used_q;

	// ----------------------------------------------------------- assertions

	a_wr_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_WALK) && pend_s1)
		else $error("bitmap write outside a walk");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) && pend_s1 |-> WORD_CW'(word_s1) < end_q)
		else $error("word in flight beyond walk end");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_FINISH)
		else $error("result raised without finishing an item");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> state_q == S_WALK)
		else $error("accepted beat did not start a walk");

endmodule

[tb/sv/tb_two_zone_page_bitmap_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_zone_page_bitmap_allocator
// Self-checking bench for the two-zone page bitmap allocator. A shadow bitmap
// and shadow zone counters predict the reply to every accepted beat, and each
// reply is checked field by field in order. Directed checks cover the zone
// edges, register clamping and counter saturation. Random traffic then runs
// under several memory sizes, with random idling on both channels and one
// long output hold-off.
// ----------------------------------------------------------------------------
module tb_two_zone_page_bitmap_allocator;
	import tpba_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD      = 300;
	localparam int SETTLE_CYCLES  = 140;

	typedef struct {
		status_t               outcome;
		logic [31:0]           page_addr;
		logic [UP_CNT_W-1:0]   upper_free;
		logic [UP_CNT_W-1:0]   upper_used;
		logic [LOW_CNT_W-1:0]  low_free;
		logic [LOW_CNT_W-1:0]  low_used;
	} bitmap_reply_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [PCNT_W-1:0]     cfg_wr_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [1:0]            opcode;
	logic                  low_zone;
	logic [31:0]           byte_address;
	logic [31:0]           byte_length;
	logic                  out_valid;
	logic                  out_stall;
	logic [1:0]            status;
	logic [31:0]           page_address;
	logic [UP_CNT_W-1:0]   upper_free_pages;
	logic [UP_CNT_W-1:0]   upper_used_pages;
	logic [LOW_CNT_W-1:0]  low_free_pages;
	logic [LOW_CNT_W-1:0]  low_used_pages;

	// shadow state of the allocator
	logic [31:0]  shadow_bitmap [WORDS];
	int           shadow_pages;
	int           upper_free_cnt;
	int           upper_used_cnt;
	int           low_free_cnt;
	int           low_used_cnt;

	bitmap_reply_t expected_replies[$];
	int            granted_pages[$];
	int            fail_count;
	int            quiet_cycles;
	int            hold_requests;
	int            holds_served;
	bit            idling_on;

	two_zone_page_bitmap_allocator dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.opcode           (opcode),
		.low_zone         (low_zone),
		.byte_address     (byte_address),
		.byte_length      (byte_length),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.status           (status),
		.page_address     (page_address),
		.upper_free_pages (upper_free_pages),
		.upper_used_pages (upper_used_pages),
		.low_free_pages   (low_free_pages),
		.low_used_pages   (low_used_pages)
	);

	always #1 clk = ~clk;

	function automatic int present_pages();
		int p;
		p = shadow_pages;
		if (p < LOW_ZONE_PAGES)
			p = LOW_ZONE_PAGES;
		if (p > MAX_PAGES)
			p = MAX_PAGES;
		return p;
	endfunction

	function automatic void reload_zone_counters();
		upper_free_cnt = present_pages() - LOW_ZONE_PAGES;
		upper_used_cnt = 0;
		low_free_cnt   = LOW_ZONE_PAGES;
		low_used_cnt   = 0;
	endfunction

	function automatic bitmap_reply_t predict_reply(opcode_t op, logic lz,
			logic [31:0] addr, logic [31:0] len);
		bitmap_reply_t r;
		int            pages;
		int            first_word;
		int            n_words;
		int            found;
		int            page;
		longint        end_page;
		logic [31:0]   w;
		pages       = present_pages();
		r.outcome   = ST_DONE;
		r.page_addr = '0;
		found       = -1;
		case (op)
			OP_ALLOC: begin
				if (lz) begin
					first_word = 0;
					n_words    = LOW_WORDS;
				end else begin
					first_word = LOW_WORDS;
					n_words    = (pages - LOW_ZONE_PAGES) / BITS_PER_WORD;
				end
				// first word with a hole, highest clear bit in it
				for (int i = 0; i < n_words && first_word + i < WORDS && found < 0; i++) begin
					w = shadow_bitmap[first_word + i];
					for (int b = BITS_PER_WORD - 1; b >= 0 && found < 0; b--)
						if (!w[b])
							found = (first_word + i) * BITS_PER_WORD + b;
				end
				if (found < 0) begin
					r.outcome = ST_OOM;
				end else begin
					shadow_bitmap[found / BITS_PER_WORD][found % BITS_PER_WORD] = 1'b1;
					r.page_addr = 32'(found) << PAGE_SHIFT;
					if (lz) begin
						if (low_used_cnt < LOW_ZONE_PAGES)
							low_used_cnt++;
						if (low_free_cnt > 0)
							low_free_cnt--;
					end else begin
						if (upper_used_cnt < pages - LOW_ZONE_PAGES)
							upper_used_cnt++;
						if (upper_free_cnt > 0)
							upper_free_cnt--;
					end
				end
			end
			OP_FREE: begin
				page = int'(addr >> PAGE_SHIFT);
				if (page >= pages)
					r.outcome = ST_RANGE;
				else
					shadow_bitmap[page / BITS_PER_WORD][page % BITS_PER_WORD] = 1'b0;
			end
			OP_RESERVE: begin
				page = int'(addr >> PAGE_SHIFT);
				if (page >= pages) begin
					r.outcome = ST_RANGE;
				end else begin
					end_page = longint'(page) + longint'(len >> PAGE_SHIFT);
					if (end_page > pages)
						end_page = pages;
					for (longint p = page; p < end_page; p++)
						shadow_bitmap[p / BITS_PER_WORD][p % BITS_PER_WORD] = 1'b1;
				end
			end
			default: ;
		endcase
		r.upper_free = UP_CNT_W'(upper_free_cnt);
		r.upper_used = UP_CNT_W'(upper_used_cnt);
		r.low_free   = LOW_CNT_W'(low_free_cnt);
		r.low_used   = LOW_CNT_W'(low_used_cnt);
		return r;
	endfunction

	function automatic logic [31:0] page_to_address(int page);
		return (32'(page) << PAGE_SHIFT) | 32'($urandom_range(0, PAGE_BYTES - 1));
	endfunction

	// one input beat; valid stays high afterwards until the next item idles or a drain
	task automatic send_item(opcode_t op, logic lz, logic [31:0] addr, logic [31:0] len);
		int            gap;
		bitmap_reply_t r;
		gap = idling_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		opcode       <= op;
		low_zone     <= lz;
		byte_address <= addr;
		byte_length  <= len;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		r = predict_reply(op, lz, addr, len);
		expected_replies.push_back(r);
		if (op == OP_ALLOC && r.outcome == ST_DONE)
			granted_pages.push_back(int'(r.page_addr >> PAGE_SHIFT));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_replies.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_memory_pages(logic [PCNT_W-1:0] value);
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en    <= 1'b0;
		shadow_pages = int'(value);
		reload_zone_counters();
	endtask

	task automatic free_page_run(int first_page, int end_page);
		for (int p = first_page; p <= end_page; p++)
			send_item(OP_FREE, 1'($urandom_range(0, 1)), page_to_address(p), $urandom());
	endtask

	task automatic random_item();
		int          sel;
		int          pages;
		int          idx;
		logic [31:0] len;
		sel   = $urandom_range(0, 99);
		pages = present_pages();
		if (sel < 45) begin
			send_item(OP_ALLOC, 1'($urandom_range(0, 1)), $urandom(), $urandom());
		end else if (sel < 70 && granted_pages.size() != 0) begin
			idx = $urandom_range(0, granted_pages.size() - 1);
			send_item(OP_FREE, 1'($urandom_range(0, 1)),
				page_to_address(granted_pages[idx]), $urandom());
			granted_pages.delete(idx);
		end else if (sel < 78) begin
			send_item(OP_FREE, 1'($urandom_range(0, 1)),
				page_to_address($urandom_range(0, pages - 1)), $urandom());
		end else if (sel < 88) begin
			len = (32'($urandom_range(0, 40)) << PAGE_SHIFT) |
				32'($urandom_range(0, PAGE_BYTES - 1));
			send_item(OP_RESERVE, 1'($urandom_range(0, 1)),
				page_to_address($urandom_range(0, pages - 1)), len);
		end else if (sel < 91) begin
			send_item(OP_RESERVE, 1'($urandom_range(0, 1)),
				page_to_address($urandom_range(0, pages - 1)), $urandom());
		end else if (sel < 95) begin
			send_item($urandom_range(0, 1) ? OP_FREE : OP_RESERVE,
				1'($urandom_range(0, 1)), $urandom(), $urandom());
		end else begin
			send_item(OP_NONE, 1'($urandom_range(0, 1)), $urandom(), $urandom());
		end
	endtask

	task automatic test_directed_ops();
		send_item(OP_ALLOC,   1'b1, 32'h0000_0000, 32'h0000_0000);
		send_item(OP_ALLOC,   1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_FREE,    1'b0, 32'h0001_FFFF, 32'h0000_0000);  // offset bits ignored
		send_item(OP_FREE,    1'b1, 32'hFFFF_FFFF, 32'h0000_0000);
		send_item(OP_FREE,    1'b0, 32'h0100_0000, 32'h0000_0000);  // first page past the end
		send_item(OP_FREE,    1'b0, 32'h00FF_F000, 32'h0000_0000);
		send_item(OP_RESERVE, 1'b0, 32'h0000_0000, 32'h0000_0000);
		send_item(OP_RESERVE, 1'b0, 32'h0000_0000, 32'h0000_0FFF);  // under one page
		send_item(OP_RESERVE, 1'b0, 32'hFFFF_F000, 32'hFFFF_FFFF);
		send_item(OP_RESERVE, 1'b1, 32'h00FF_F000, 32'hFFFF_FFFF);  // clamped at the end
		send_item(OP_NONE,    1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_NONE,    1'b0, 32'h0000_0000, 32'h0000_0000);
		send_item(OP_RESERVE, 1'b0, 32'h0000_0000, 32'h0002_0000);  // fills word 0
		send_item(OP_ALLOC,   1'b1, 32'h0000_0000, 32'h0000_0000);
		send_item(OP_FREE,    1'b0, 32'h0000_0000, 32'h0000_0000);
		send_item(OP_ALLOC,   1'b1, 32'h0000_0000, 32'h0000_0000);  // page zero
		send_item(OP_RESERVE, 1'b0, 32'h0010_0000, 32'h0010_0000);
		send_item(OP_ALLOC,   1'b0, 32'h0000_0000, 32'h0000_0000);
		send_item(OP_RESERVE, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF);  // whole memory
		send_item(OP_ALLOC,   1'b1, 32'h0000_0000, 32'h0000_0000);
		send_item(OP_ALLOC,   1'b0, 32'h0000_0000, 32'h0000_0000);
	endtask

	task automatic test_zone_exhaustion();
		idling_on = 1'b0;
		free_page_run(0, LOW_ZONE_PAGES + BITS_PER_WORD - 1);
		idling_on = 1'b1;
		// upper zone of 44 pages: only the one whole word is handed out
		set_memory_pages(13'd300);
		repeat (LOW_ZONE_PAGES + 1) send_item(OP_ALLOC, 1'b1, $urandom(), $urandom());
		repeat (BITS_PER_WORD + 1) send_item(OP_ALLOC, 1'b0, $urandom(), $urandom());
		free_page_run(10, 12);
		free_page_run(260, 262);
		repeat (4) send_item(OP_ALLOC, 1'b1, $urandom(), $urandom());
		repeat (4) send_item(OP_ALLOC, 1'b0, $urandom(), $urandom());
		send_item(OP_RESERVE, 1'b0, page_to_address(300), 32'hFFFF_FFFF);
		send_item(OP_RESERVE, 1'b1, page_to_address(299), 32'hFFFF_FFFF);
		send_item(OP_FREE,    1'b0, page_to_address(300), 32'h0);
		// one-word upper zone, driven past its size so the counters saturate
		set_memory_pages(13'd288);
		free_page_run(256, 287);
		repeat (BITS_PER_WORD + 1) send_item(OP_ALLOC, 1'b0, $urandom(), $urandom());
		free_page_run(270, 271);
		repeat (2) send_item(OP_ALLOC, 1'b0, $urandom(), $urandom());
		send_item(OP_RESERVE, 1'b0, page_to_address(288), 32'h0000_1000);
		send_item(OP_RESERVE, 1'b0, page_to_address(287), 32'hFFFF_FFFF);
	endtask

	task automatic test_register_extremes();
		logic [PCNT_W-1:0] settings [6];
		settings = '{13'd0, 13'd255, 13'd8191, 13'd4097, 13'd256, 13'd4096};
		foreach (settings[i]) begin
			set_memory_pages(settings[i]);
			send_item(OP_ALLOC, 1'b0, $urandom(), $urandom());
			send_item(OP_ALLOC, 1'b1, $urandom(), $urandom());
			send_item(OP_FREE, 1'b0, page_to_address(present_pages()), $urandom());
			send_item(OP_FREE, 1'b0, page_to_address(present_pages() - 1), $urandom());
		end
	endtask

	// result held back for a long stretch while the sender keeps offering beats
	task automatic test_output_hold_off();
		idling_on = 1'b0;
		hold_requests++;
		repeat (8) random_item();
		drain_results();
		idling_on = 1'b1;
	endtask

	task automatic test_sender_pause();
		repeat (6) random_item();
		drain_results();
		repeat (6) random_item();
	endtask

	task automatic test_random_traffic(logic [PCNT_W-1:0] pages_setting, int n_items);
		set_memory_pages(pages_setting);
		for (int i = 0; i < n_items; i++) begin
			if (i % 64 == 0)
				idling_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 39) == 0)
				drain_results();
			random_item();
		end
		idling_on = 1'b1;
	endtask

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		in_valid      = 1'b0;
		opcode        = OP_ALLOC;
		low_zone      = 1'b0;
		byte_address  = '0;
		byte_length   = '0;
		fail_count    = 0;
		hold_requests = 0;
		idling_on     = 1'b1;
		foreach (shadow_bitmap[i])
			shadow_bitmap[i] = '0;
		shadow_pages = MAX_PAGES;
		reload_zone_counters();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_ops();
		test_zone_exhaustion();
		test_register_extremes();
		test_output_hold_off();
		test_sender_pause();
		test_random_traffic(13'd512, 200);
		test_random_traffic(13'd300, 150);
		test_random_traffic(13'd4096, 250);
		test_random_traffic(13'd1024, 270);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// result side: a random stall after each beat, or a long hold-off on request
	initial begin
		int w;
		out_stall    = 1'b0;
		holds_served = 0;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_served) begin
				holds_served++;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 1'b0;
			end else if (out_valid && !out_stall) begin
				w = idling_on ? $urandom_range(0, 4) : 0;
				if (w > 0) begin
					out_stall <= 1'b1;
					repeat (w) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			fail_count++;
			$error("%s: expected %0d, actual %0d", name, want, got);
		end
	endtask

	always @(posedge clk) begin
		bitmap_reply_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_replies.size() == 0) begin
				fail_count++;
				$error("result beat with no reply outstanding");
			end else begin
				want = expected_replies.pop_front();
				check_field("status", 32'(want.outcome), 32'(status));
				check_field("page_address", want.page_addr, page_address);
				check_field("upper_free_pages", 32'(want.upper_free), 32'(upper_free_pages));
				check_field("upper_used_pages", 32'(want.upper_used), 32'(upper_used_pages));
				check_field("low_free_pages", 32'(want.low_free), 32'(low_free_pages));
				check_field("low_used_pages", 32'(want.low_used), 32'(low_used_pages));
			end
		end
	end

	// cycles with no beat on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial quiet_cycles = 0;

endmodule
